// File: rtl/rgb_led_tick_controller_assert.svh
// Assertion macros shared by the checker of the RGB LED tick controller.
`ifndef RGB_LED_TICK_CONTROLLER_ASSERT_SVH
`define RGB_LED_TICK_CONTROLLER_ASSERT_SVH

// Overlapping implication, sampled on the rising clock edge, quiet during reset.
`define RLTC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// Non-overlapping implication, sampled on the rising clock edge, quiet during reset.
`define RLTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

// File: rtl/rltc_pkg.sv
// Package with the types, codes and constants of the RGB LED tick controller.
package rltc_pkg;

    // Timing and level constants.
    localparam int TICKS_PER_SECOND = 100;
    localparam int BLINK_TICKS      = 50;
    localparam int LEVEL_MAX_INT    = 250;
    localparam int LEVEL_MIN_INT    = 0;
    localparam int COLOR_STEP_INT   = 25;

    // Derived constants at the widths of the counters and levels they load or compare.
    localparam logic [6:0] BLINK_LIMIT   = 7'(BLINK_TICKS);
    localparam logic [9:0] TEMP_ON_TICKS = 10'(5 * TICKS_PER_SECOND);
    localparam logic [8:0] SAVE_TICKS    = 9'(2 * TICKS_PER_SECOND);
    localparam logic [9:0] FADE_PHASE_1  = 10'(1 * TICKS_PER_SECOND);
    localparam logic [9:0] FADE_PHASE_2  = 10'(2 * TICKS_PER_SECOND);
    localparam logic [9:0] FADE_PHASE_3  = 10'(3 * TICKS_PER_SECOND);
    localparam logic [9:0] FADE_PHASE_4  = 10'(4 * TICKS_PER_SECOND);
    localparam logic [9:0] FADE_PHASE_5  = 10'(5 * TICKS_PER_SECOND);
    localparam logic [9:0] FADE_PHASE_6  = 10'(6 * TICKS_PER_SECOND);
    localparam logic [7:0] LEVEL_MAX     = 8'(LEVEL_MAX_INT);
    localparam logic [7:0] LEVEL_MIN     = 8'(LEVEL_MIN_INT);
    localparam logic [7:0] COLOR_STEP    = 8'(COLOR_STEP_INT);

    // Always-on register value: enable ignores fake power-off when powered, no notify.
    localparam logic [7:0] MODE_FORCE_ON = 8'd2;

    // Item function codes.
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_SET    = 2'd1;
    localparam logic [1:0] FUNC_NOTIFY = 2'd2;

    // One input beat.
    typedef struct packed {
        logic [1:0] func;
        logic       machine_power;
        logic       fake_power_off;
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
    } in_item_t;

    // One result beat.
    typedef struct packed {
        logic       led_enable;
        logic [7:0] red_drive;
        logic [7:0] green_drive;
        logic [7:0] blue_drive;
        logic       drive_update;
        logic       save_request;
    } out_item_t;

    // Contents of the input register as seen by the core.
    typedef struct packed {
        logic     valid;
        in_item_t item;
    } stage_t;

endpackage

// File: rtl/rgb_led_tick_controller.sv
// Top level of the RGB LED tick controller.
// The controller takes one beat per clock cycle (tick, colour set or notify) while the
// output is not stalled and returns one result beat for each. A beat is held in the input
// register and then passes through the update logic into the result register, from which
// its result is offered. All state, including the fade counters and stored colour, is
// updated in that single pass, so a new beat may follow every cycle while the output is not
// stalled; a stalled output holds one finished beat while one more waits in the input
// register. The always-on register is written through the configuration channel, which is
// always ready, and should only be written while no beats are in flight.
module rgb_led_tick_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rltc_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output rltc_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);
    import rltc_pkg::*;

    logic [7:0] mode_reg;
    logic [7:0] mode_next;
    stage_t     stage;
    logic       take;

    // Configuration register: always ready.
    assign cfg_ready = 1'b1;
    assign mode_next = (cfg_valid && cfg_ready) ? cfg_data : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    rltc_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .take     (take),
        .stage    (stage)
    );

    rltc_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .stage          (stage),
        .always_on_mode (mode_reg),
        .take           (take),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data)
    );

endmodule

// File: rtl/rltc_in_stage.sv
// Input register of the RGB LED tick controller.
module rltc_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  rltc_pkg::in_item_t in_data,
    input  logic              take,
    output rltc_pkg::stage_t  stage
);
    import rltc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;

    // The register is full and its beat cannot move on to the core.
    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    // Occupancy: filled by an accepted beat, emptied when the core takes it.
    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload is only loaded on acceptance.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

// File: rtl/rltc_core.sv
// Controller state, per-item update logic and result register.
module rltc_core (
    input  logic               clk,
    input  logic               rst_n,
    input  rltc_pkg::stage_t   stage,
    input  logic [7:0]         always_on_mode,
    output logic               take,
    output logic               out_valid,
    input  logic               out_stall,
    output rltc_pkg::out_item_t out_data
);
    import rltc_pkg::*;

    // Controller state.
    logic            enable_reg,  enable_next;
    logic            notify_reg,  notify_next;
    logic [6:0]      blink_reg,   blink_next;
    logic [9:0]      temp_reg,    temp_next;
    logic [8:0]      save_reg,    save_next;
    logic [9:0]      fcount_reg,  fcount_next;
    logic            pending_reg, pending_next;
    logic [2:0][7:0] stored_reg,  stored_next;
    logic [2:0][7:0] fade_reg,    fade_next;
    logic [2:0][7:0] drive_reg,   drive_next;

    // Result register.
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg,  out_data_next;

    // Working values.
    logic            fire;
    in_item_t        it;
    logic [6:0]      blink_inc;
    logic [9:0]      fcount_inc;
    logic [2:0][7:0] fade_adv;
    logic [2:0][7:0] set_levels;
    logic            set_differ;
    logic            all_max;
    logic            en;
    logic            update;
    logic            save_due;

    // The result register can take a new beat when empty or being emptied.
    assign take = !out_valid_reg || !out_stall;
    assign fire = stage.valid && take;
    assign it   = stage.item;

    assign blink_inc  = blink_reg + 7'd1;
    assign fcount_inc = fcount_reg + 10'd1;
    assign all_max    = (stored_reg[0] == LEVEL_MAX) && (stored_reg[1] == LEVEL_MAX) &&
                        (stored_reg[2] == LEVEL_MAX);

    // Six-phase fade: each phase one second, the last wraps back to the start.
    always_comb
    begin
        fade_adv = fade_reg;
        priority if (fcount_inc > FADE_PHASE_6)
        begin
            fade_adv = {LEVEL_MAX, 8'd0, 8'd0};
        end
        else if (fcount_inc > FADE_PHASE_5)
        begin
            fade_adv = {LEVEL_MAX, fade_reg[1] - COLOR_STEP, 8'd0};
        end
        else if (fcount_inc > FADE_PHASE_4)
        begin
            fade_adv = {fade_reg[2] + COLOR_STEP, LEVEL_MAX, 8'd0};
        end
        else if (fcount_inc > FADE_PHASE_3)
        begin
            fade_adv = {8'd0, LEVEL_MAX, fade_reg[0] - COLOR_STEP};
        end
        else if (fcount_inc > FADE_PHASE_2)
        begin
            fade_adv = {8'd0, fade_reg[1] + COLOR_STEP, LEVEL_MAX};
        end
        else if (fcount_inc > FADE_PHASE_1)
        begin
            fade_adv = {fade_reg[2] - COLOR_STEP, 8'd0, LEVEL_MAX};
        end
        else
        begin
            fade_adv = {LEVEL_MAX, 8'd0, fade_reg[0] + COLOR_STEP};
        end
    end

    // Requested levels clamped to the minimum, and whether they change the colour.
    always_comb
    begin
        set_levels[0] = (it.red_level   < LEVEL_MIN) ? LEVEL_MIN : it.red_level;
        set_levels[1] = (it.green_level < LEVEL_MIN) ? LEVEL_MIN : it.green_level;
        set_levels[2] = (it.blue_level  < LEVEL_MIN) ? LEVEL_MIN : it.blue_level;
        set_differ    = (set_levels != stored_reg);
    end

    // Per-item state update.
    always_comb
    begin
        enable_next  = enable_reg;
        notify_next  = notify_reg;
        blink_next   = blink_reg;
        temp_next    = temp_reg;
        save_next    = save_reg;
        fcount_next  = fcount_reg;
        pending_next = pending_reg;
        stored_next  = stored_reg;
        fade_next    = fade_reg;
        drive_next   = drive_reg;
        en           = 1'b0;
        update       = 1'b0;
        save_due     = 1'b0;
        if (fire)
        begin
            unique case (it.func)
                FUNC_TICK:
                begin
                    // Enable decision from power, notify blinking, mode and the temporary enable.
                    if (it.machine_power)
                    begin
                        if (notify_reg)
                        begin
                            blink_next = blink_inc;
                            if (blink_inc > BLINK_LIMIT)
                            begin
                                blink_next = 7'd0;
                                en         = !enable_reg;
                            end
                        end
                        else if (always_on_mode == MODE_FORCE_ON)
                        begin
                            en = 1'b1;
                        end
                        else
                        begin
                            en = !it.fake_power_off;
                        end
                    end
                    if (temp_reg != 10'd0)
                    begin
                        temp_next = temp_reg - 10'd1;
                        en        = 1'b1;
                    end
                    enable_next = en;

                    // Drive refresh: fade when white at full level and enabled, else pending colour.
                    if (it.machine_power)
                    begin
                        if (all_max)
                        begin
                            if (en)
                            begin
                                fcount_next = (fcount_inc > FADE_PHASE_6) ? 10'd0 : fcount_inc;
                                fade_next   = fade_adv;
                                drive_next  = fade_adv;
                                update      = 1'b1;
                            end
                        end
                        else if (pending_reg)
                        begin
                            drive_next   = stored_reg;
                            pending_next = 1'b0;
                            update       = 1'b1;
                        end
                    end
                    else
                    begin
                        pending_next = 1'b1;
                    end

                    // Save delay countdown.
                    if (save_reg != 9'd0)
                    begin
                        save_next = save_reg - 9'd1;
                        save_due  = (save_reg == 9'd1);
                    end
                end
                FUNC_SET:
                begin
                    pending_next = 1'b1;
                    temp_next    = TEMP_ON_TICKS;
                    if (set_differ)
                    begin
                        stored_next = set_levels;
                        save_next   = SAVE_TICKS;
                    end
                end
                FUNC_NOTIFY:
                begin
                    notify_next = 1'b1;
                end
                default:
                begin
                    // Unused code: state is left alone.
                end
            endcase
        end
    end

    // Result register contents.
    always_comb
    begin
        out_valid_next = take ? stage.valid : out_valid_reg;
        out_data_next  = out_data_reg;
        if (fire)
        begin
            out_data_next.led_enable   = enable_next;
            out_data_next.red_drive    = drive_next[0];
            out_data_next.green_drive  = drive_next[1];
            out_data_next.blue_drive   = drive_next[2];
            out_data_next.drive_update = update;
            out_data_next.save_request = save_due;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            notify_reg    <= 1'b0;
            blink_reg     <= '0;
            temp_reg      <= '0;
            save_reg      <= '0;
            fcount_reg    <= '0;
            pending_reg   <= 1'b0;
            stored_reg    <= '0;
            fade_reg      <= '0;
            drive_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            enable_reg    <= enable_next;
            notify_reg    <= notify_next;
            blink_reg     <= blink_next;
            temp_reg      <= temp_next;
            save_reg      <= save_next;
            fcount_reg    <= fcount_next;
            pending_reg   <= pending_next;
            stored_reg    <= stored_next;
            fade_reg      <= fade_next;
            drive_reg     <= drive_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/rltc_checker.sv
// Port-level checker of the RGB LED tick controller and its binding.
`include "rgb_led_tick_controller_assert.svh"

module rltc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input rltc_pkg::out_item_t out_data
);

    logic in_beat;

    assign in_beat = in_valid && !in_stall;

    // A stalled result beat stays offered.
    `RLTC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid,
        "result beat withdrawn while stalled")
    // A stalled result beat keeps its payload.
    `RLTC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data),
        "result payload changed while stalled")
    // With no result waiting, the input side never stalls.
    `RLTC_ASSERT_NOW(a_no_false_stall, clk, rst_n, !out_valid, !in_stall,
        "input stalled with an empty result register")
    // Every accepted beat is followed by a result on offer once it has passed the input register.
    `RLTC_ASSERT_NOW(a_latency, clk, rst_n, in_beat, ##2 out_valid,
        "no result beat two cycles after acceptance")

endmodule

bind rgb_led_tick_controller rltc_checker u_checker (.*);

// File: test/led_result_checker.sv
// Checker that predicts and compares the result beats of the RGB LED tick controller.
module led_result_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  rltc_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  rltc_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [7:0]          cfg_data,
    output int                  bad_results,
    output int                  results_pending
);
    import rltc_pkg::*;

    // Predicted controller state.
    logic [7:0] mode_q;
    logic       en_q;
    logic       notify_q;
    logic       pend_q;
    logic [6:0] blink_q;
    logic [9:0] temp_on_q;
    logic [8:0] save_q;
    logic [9:0] fade_q;
    logic [7:0] stored_q [3];
    logic [7:0] fade_lv [3];
    logic [7:0] drive_q [3];

    // Results owed by the controller, oldest first.
    out_item_t led_results_due [$];

    // Advances the predicted state by one input beat and returns the result it causes.
    function automatic out_item_t next_led_result(in_item_t beat);
        out_item_t  r;
        logic       en;
        logic       differ;
        logic [7:0] lv [3];
        r = '0;
        case (beat.func)
            FUNC_TICK:
            begin
                // Decide the power enable.
                en = 1'b0;
                if (beat.machine_power)
                begin
                    if (notify_q)
                    begin
                        blink_q = blink_q + 7'd1;
                        if (blink_q > BLINK_LIMIT)
                        begin
                            blink_q = '0;
                            en = !en_q;
                        end
                    end
                    else if (mode_q == MODE_FORCE_ON)
                        en = 1'b1;
                    else
                        en = !beat.fake_power_off;
                end
                if (temp_on_q != '0)
                begin
                    temp_on_q = temp_on_q - 10'd1;
                    en = 1'b1;
                end
                en_q = en;

                // Drive the levels: the white fade, or a pending colour change.
                if (beat.machine_power)
                begin
                    if (stored_q[0] == LEVEL_MAX && stored_q[1] == LEVEL_MAX &&
                        stored_q[2] == LEVEL_MAX)
                    begin
                        if (en_q)
                        begin
                            fade_q = fade_q + 10'd1;
                            if (fade_q > FADE_PHASE_6)
                            begin
                                fade_q = '0;
                                fade_lv[0] = '0;
                                fade_lv[1] = '0;
                                fade_lv[2] = LEVEL_MAX;
                            end
                            else if (fade_q > FADE_PHASE_5)
                            begin
                                fade_lv[0] = '0;
                                fade_lv[1] = fade_lv[1] - COLOR_STEP;
                                fade_lv[2] = LEVEL_MAX;
                            end
                            else if (fade_q > FADE_PHASE_4)
                            begin
                                fade_lv[0] = '0;
                                fade_lv[1] = LEVEL_MAX;
                                fade_lv[2] = fade_lv[2] + COLOR_STEP;
                            end
                            else if (fade_q > FADE_PHASE_3)
                            begin
                                fade_lv[0] = fade_lv[0] - COLOR_STEP;
                                fade_lv[1] = LEVEL_MAX;
                                fade_lv[2] = '0;
                            end
                            else if (fade_q > FADE_PHASE_2)
                            begin
                                fade_lv[0] = LEVEL_MAX;
                                fade_lv[1] = fade_lv[1] + COLOR_STEP;
                                fade_lv[2] = '0;
                            end
                            else if (fade_q > FADE_PHASE_1)
                            begin
                                fade_lv[0] = LEVEL_MAX;
                                fade_lv[1] = '0;
                                fade_lv[2] = fade_lv[2] - COLOR_STEP;
                            end
                            else
                            begin
                                fade_lv[0] = fade_lv[0] + COLOR_STEP;
                                fade_lv[1] = '0;
                                fade_lv[2] = LEVEL_MAX;
                            end
                            drive_q = fade_lv;
                            r.drive_update = 1'b1;
                        end
                    end
                    else if (pend_q)
                    begin
                        drive_q = stored_q;
                        pend_q = 1'b0;
                        r.drive_update = 1'b1;
                    end
                end
                else
                    pend_q = 1'b1;

                // Count down to the delayed save.
                if (save_q != '0)
                begin
                    save_q = save_q - 9'd1;
                    if (save_q == '0)
                        r.save_request = 1'b1;
                end
            end
            FUNC_SET:
            begin
                // Clamp and store the colour; re-arm the save only when it changed.
                lv[0] = beat.red_level;
                lv[1] = beat.green_level;
                lv[2] = beat.blue_level;
                differ = 1'b0;
                for (int i = 0; i < 3; i++)
                begin
                    if (lv[i] < LEVEL_MIN)
                        lv[i] = LEVEL_MIN;
                    if (lv[i] != stored_q[i])
                        differ = 1'b1;
                end
                pend_q = 1'b1;
                temp_on_q = TEMP_ON_TICKS;
                if (differ)
                begin
                    stored_q = lv;
                    save_q = SAVE_TICKS;
                end
            end
            FUNC_NOTIFY:
                notify_q = 1'b1;
            default:
                ;
        endcase
        r.led_enable  = en_q;
        r.red_drive   = drive_q[0];
        r.green_drive = drive_q[1];
        r.blue_drive  = drive_q[2];
        return r;
    endfunction

    // Follow the channels: predict on each input beat, compare on each result beat.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            mode_q    = '0;
            en_q      = 1'b0;
            notify_q  = 1'b0;
            pend_q    = 1'b0;
            blink_q   = '0;
            temp_on_q = '0;
            save_q    = '0;
            fade_q    = '0;
            for (int i = 0; i < 3; i++)
            begin
                stored_q[i] = '0;
                fade_lv[i]  = '0;
                drive_q[i]  = '0;
            end
            led_results_due.delete();
            bad_results     = 0;
            results_pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mode_q = cfg_data;
            if (in_valid && !in_stall)
                led_results_due.push_back(next_led_result(in_data));
            if (out_valid && !out_stall)
            begin
                if (led_results_due.size() == 0)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("%0t: result beat with none expected: %p", $time, out_data);
                end
                else
                begin
                    want = led_results_due.pop_front();
                    if (out_data.led_enable   !== want.led_enable   ||
                        out_data.red_drive    !== want.red_drive    ||
                        out_data.green_drive  !== want.green_drive  ||
                        out_data.blue_drive   !== want.blue_drive   ||
                        out_data.drive_update !== want.drive_update ||
                        out_data.save_request !== want.save_request)
                    begin
                        bad_results++;
                        if (bad_results <= 10)
                        begin
                            $display("%0t: result mismatch", $time);
                            $display("  expected en %0b rgb %0d/%0d/%0d update %0b save %0b",
                                     want.led_enable, want.red_drive, want.green_drive,
                                     want.blue_drive, want.drive_update, want.save_request);
                            $display("  actual   en %0b rgb %0d/%0d/%0d update %0b save %0b",
                                     out_data.led_enable, out_data.red_drive,
                                     out_data.green_drive, out_data.blue_drive,
                                     out_data.drive_update, out_data.save_request);
                        end
                    end
                end
            end
            results_pending = led_results_due.size();
        end
    end

endmodule

// File: test/tb.sv
// Testbench top for the RGB LED tick controller: clock, reset, stimulus and verdict.
module tb;
    import rltc_pkg::*;

    localparam logic [1:0] FUNC_SPARE  = 2'd3;
    localparam int         IN_BITS     = $bits(in_item_t);
    localparam int         QUIET_LIMIT = 1000;
    localparam int         HOLD_CYCLES = 80;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    in_item_t   in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = '0;
    int         bad_results;
    int         results_pending;
    int         quiet_cycles = 0;
    bit         calm     = 1'b0;
    bit         hold_req = 1'b0;
    logic [7:0] last_colour [3] = '{8'h00, 8'h00, 8'h00};

    rgb_led_tick_controller DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    led_result_checker result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .bad_results     (bad_results),
        .results_pending (results_pending)
    );

    // Free-running clock.
    always #5 clk = ~clk;

    // Watchdog: too long without any beat moving ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side: random stalls, none while calm, and one long hold when asked.
    initial
    begin : receiver
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES - 1;
                hold_done = 1'b1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(0, 99) < 25);
        end
    end

    // A beat with random contents apart from the function and the two power flags.
    function automatic in_item_t beat_of(logic [1:0] f, logic power, logic fake);
        in_item_t beat;
        beat = IN_BITS'($urandom);
        beat.func           = f;
        beat.machine_power  = power;
        beat.fake_power_off = fake;
        return beat;
    endfunction

    // A colour set beat; the colour is remembered so that it can be repeated.
    function automatic in_item_t set_beat(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        in_item_t beat;
        beat = beat_of(FUNC_SET, 1'($urandom), 1'($urandom));
        beat.red_level   = r;
        beat.green_level = g;
        beat.blue_level  = b;
        last_colour[0] = r;
        last_colour[1] = g;
        last_colour[2] = b;
        return beat;
    endfunction

    function automatic logic [7:0] extreme_level();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'hFE;
            default: return LEVEL_MAX;
        endcase
    endfunction

    // Random colour: white, the same colour again, extremes, or anything.
    function automatic in_item_t colour_beat();
        case ($urandom_range(0, 5))
            0: return set_beat(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
            1: return set_beat(last_colour[0], last_colour[1], last_colour[2]);
            2: return set_beat(extreme_level(), extreme_level(), extreme_level());
            default: return set_beat(8'($urandom), 8'($urandom), 8'($urandom));
        endcase
    endfunction

    // Offer one beat, perhaps after a short gap, and hold it until it is taken.
    task automatic send_beat(input in_item_t beat);
        if (!calm && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // Stop offering and wait until every result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (results_pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write the always-on register while the controller is idle.
    task automatic write_mode(input logic [7:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Episodes of one colour set followed by a run of mostly ticks.
    task automatic run_episodes(input int n_items, input bit with_notify, input bit long_first);
        int sent;
        int run_len;
        int roll;
        sent = 0;
        while (sent < n_items)
        begin
            send_beat(colour_beat());
            sent++;
            if ((long_first && sent == 1) || $urandom_range(0, 3) == 0)
                run_len = $urandom_range(520, 650);
            else
                run_len = $urandom_range(5, 60);
            for (int k = 0; k < run_len && sent < n_items; k++)
            begin
                roll = $urandom_range(0, 99);
                // Long runs carry no colour set so that the temporary enable runs out.
                if (run_len < 100 && roll < 4)
                    send_beat(colour_beat());
                else if (roll < 8)
                    send_beat(beat_of(FUNC_SPARE, 1'($urandom), 1'($urandom)));
                else if (with_notify && roll < 10)
                    send_beat(beat_of(FUNC_NOTIFY, 1'($urandom), 1'($urandom)));
                else
                    send_beat(beat_of(FUNC_TICK, $urandom_range(0, 99) < 85,
                                      1'($urandom)));
                sent++;
            end
        end
    endtask

    // Reset, directed beats, random phases, then the verdict.
    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_mode(8'h00);

        // Power off and on, fake power-off, ignored function code, colour sets.
        send_beat(beat_of(FUNC_TICK, 1'b0, 1'b0));
        send_beat(beat_of(FUNC_TICK, 1'b1, 1'b0));
        send_beat(beat_of(FUNC_TICK, 1'b1, 1'b1));
        send_beat('1);
        send_beat(set_beat(8'hFF, 8'h00, 8'hFE));
        send_beat(beat_of(FUNC_TICK, 1'b1, 1'b1));
        send_beat(set_beat(8'hFF, 8'h00, 8'hFE));
        send_beat(beat_of(FUNC_TICK, 1'b0, 1'b1));
        send_beat(beat_of(FUNC_TICK, 1'b1, 1'b0));
        // White starts the fade; a power-off tick in between holds it.
        send_beat(set_beat(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX));
        send_beat(beat_of(FUNC_TICK, 1'b1, 1'b0));
        send_beat(beat_of(FUNC_TICK, 1'b1, 1'b1));
        send_beat(beat_of(FUNC_TICK, 1'b0, 1'b0));
        send_beat(beat_of(FUNC_TICK, 1'b1, 1'b0));
        // An all-0xFE colour is not full white and so is an ordinary colour.
        send_beat(set_beat(8'hFE, 8'hFE, 8'hFE));
        send_beat(beat_of(FUNC_TICK, 1'b1, 1'b0));
        send_beat(set_beat(8'h00, 8'h00, 8'h00));
        send_beat(beat_of(FUNC_TICK, 1'b1, 1'b0));
        send_beat(in_item_t'{func: FUNC_SPARE, default: '0});
        send_beat(beat_of(FUNC_TICK, 1'b1, 1'b1));

        // Mixed traffic with an ordinary always-on setting.
        write_mode(8'($urandom_range(3, 254)));
        run_episodes(600, 1'b0, 1'b1);

        // Forced-on mode, white, and enough ticks without gaps for the fade to wrap.
        write_mode(MODE_FORCE_ON);
        calm = 1'b1;
        send_beat(set_beat(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX));
        repeat (680) send_beat(beat_of(FUNC_TICK, $urandom_range(0, 99) < 97, 1'($urandom)));
        calm = 1'b0;

        // Top setting, with one long hold on the result side.
        write_mode(8'hFF);
        hold_req = 1'b1;
        run_episodes(300, 1'b0, 1'b0);

        // Notify comes last since it stays set until reset.
        write_mode(8'($urandom));
        send_beat(beat_of(FUNC_NOTIFY, 1'($urandom), 1'($urandom)));
        run_episodes(250, 1'b1, 1'b0);

        drain();
        if (bad_results == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/rltc_pkg.sv
rtl/rltc_in_stage.sv
rtl/rltc_core.sv
rtl/rgb_led_tick_controller.sv
rtl/rltc_checker.sv
test/led_result_checker.sv
test/tb.sv
